// ===== sv/ebj_pkg.sv =====
// ----------------------------------------------------------------------------
// ebj_pkg: shared types and constants of the backoff controller
// Field widths, action codes, register indexes and reset values, and the divider status type.
// ----------------------------------------------------------------------------
package ebj_pkg;

   localparam int CODE_W     = 8;
   localparam int WAIT_W     = 32;
   localparam int RAND_W     = 64;
   localparam int ACT_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // action codes
   localparam logic [ACT_W-1:0] ACT_WAIT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_OK     = 2'd1;
   localparam logic [ACT_W-1:0] ACT_GIVEUP = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CFGERR = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WINDOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ATTEMPT_LIM = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] BASE_WINDOW_RST = 32'd100;
   localparam logic [CSR_DATA_W-1:0] MAX_WINDOW_RST  = 32'd30000;
   localparam logic [CSR_DATA_W-1:0] ATTEMPT_LIM_RST = 32'd0;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/ebj_req_if.sv =====
// ----------------------------------------------------------------------------
// ebj_req_if: request channel
// One attempt outcome with its error code and random word, valid/ready.
// ----------------------------------------------------------------------------
interface ebj_req_if;
   import ebj_pkg::*;

   logic              valid;
   logic              ready;
   logic              attempt_ok;
   logic [CODE_W-1:0] fail_code;
   logic [RAND_W-1:0] random_word;

   modport source (output valid, output attempt_ok, output fail_code,
                   output random_word, input ready);
   modport sink   (input valid, input attempt_ok, input fail_code,
                   input random_word, output ready);
endinterface

// ===== sv/ebj_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ebj_rsp_if: response channel
// Action, wait time and final error code, valid/ready.
// ----------------------------------------------------------------------------
interface ebj_rsp_if;
   import ebj_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [WAIT_W-1:0] wait_ms;
   logic [CODE_W-1:0] final_code;

   modport source (output valid, output action, output wait_ms,
                   output final_code, input ready);
   modport sink   (input valid, input action, input wait_ms,
                   input final_code, output ready);
endinterface

// ===== sv/ebj_mod_unit.sv =====
// ----------------------------------------------------------------------------
// ebj_mod_unit: bit-serial modulo
// Restoring remainder, one dividend bit per cycle over all RANDOM_WIDTH dividend bits.
// ----------------------------------------------------------------------------
module ebj_mod_unit #(
   parameter int RANDOM_WIDTH = 64,
   parameter int WINDOW_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [RANDOM_WIDTH-1:0]   dividend,
   input  logic [WINDOW_WIDTH-1:0]   divisor,
   output ebj_pkg::div_stat_type     stat,
   output logic [WINDOW_WIDTH-1:0]   remainder
);
   import ebj_pkg::*;

   localparam int CNT_W = $clog2(RANDOM_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RANDOM_WIDTH - 1);

   logic                    busy_ff, busy_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [RANDOM_WIDTH-1:0] dvd_ff, dvd_in;
   logic [WINDOW_WIDTH-1:0] dvs_ff, dvs_in;
   logic [WINDOW_WIDTH-1:0] rem_ff, rem_in;

   logic [WINDOW_WIDTH:0]   shifted;
   logic [WINDOW_WIDTH+1:0] diff;
   logic [WINDOW_WIDTH-1:0] rem_step;

   always_comb begin
      shifted  = {rem_ff, dvd_ff[RANDOM_WIDTH-1]};
      diff     = {1'b0, shifted} - {2'b00, dvs_ff};
      // borrow means the shifted remainder stays below the divisor
      rem_step = diff[WINDOW_WIDTH+1] ? shifted[WINDOW_WIDTH-1:0]
                                      : diff[WINDOW_WIDTH-1:0];

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_STEP;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = rem_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == '0);
   assign remainder = rem_step;

endmodule

// ===== sv/exponential_backoff_jitter_top.sv =====
// ----------------------------------------------------------------------------
// exponential_backoff_jitter_top: retry controller, capped backoff with jitter
// Turns attempt outcomes into wait, success, give-up or config-error actions.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one attempt outcome per request: attempt_ok, fail_code and
//   a random word. rsp_ch returns exactly one response per request: action,
//   wait_ms (wait actions only) and final_code (give-up only).
//   csr_we/csr_index/csr_wdata write base window (0), max window (1) and
//   attempt limit (2); a base window write also reloads the current window.
//   Write registers only while no request is in flight.
// Sequencing:
//   success, give-up and config-error requests go from idle to finish; a wait
//   request first runs the bit-serial modulo, one random bit per cycle, in the
//   divide state. The finish state loads the response register and returns
//   to idle, so a new request is taken only after the previous response is
//   loaded.
// Reset: registers return to 100 / 30000 / 0, window to base, count to 0.
// Stall: the response register holds until rsp_ch.ready; the next request
//   is still taken and finished, then waits behind it.
// ----------------------------------------------------------------------------
module exponential_backoff_jitter_top #(
   parameter int RANDOM_WIDTH = 64,
   parameter int WINDOW_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   ebj_req_if.sink                           req_ch,
   ebj_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [ebj_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ebj_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ebj_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [WINDOW_WIDTH-1:0] base_ff, base_in;
   logic [WINDOW_WIDTH-1:0] max_ff, max_in;
   logic [CSR_DATA_W-1:0]   limit_ff, limit_in;
   logic [WINDOW_WIDTH-1:0] window_ff, window_in;
   logic [CSR_DATA_W-1:0]   count_ff, count_in;
   logic [ACT_W-1:0]        act_ff, act_in;
   logic [WAIT_W-1:0]       wait_ff, wait_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]        rsp_act_ff, rsp_act_in;
   logic [WAIT_W-1:0]       rsp_wait_ff, rsp_wait_in;
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;

   logic                    accept;
   logic                    div_start;
   logic [WINDOW_WIDTH-1:0] win;
   logic [WINDOW_WIDTH-1:0] cap;
   logic [CSR_DATA_W-1:0]   count_inc;
   logic [WINDOW_WIDTH-1:0] div_rem;
   div_stat_type            div_stat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      win       = (window_ff == '0) ? WINDOW_WIDTH'(1) : window_ff;
      cap       = (max_ff == '0) ? WINDOW_WIDTH'(1) : max_ff;
      count_inc = count_ff + CSR_DATA_W'(1);

      state_in     = state_ff;
      base_in      = base_ff;
      max_in       = max_ff;
      limit_in     = limit_ff;
      window_in    = window_ff;
      count_in     = count_ff;
      act_in       = act_ff;
      wait_in      = wait_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_code_in  = rsp_code_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FINISH;
               wait_in  = '0;
               code_in  = '0;
               if (base_ff == '0) begin
                  act_in    = ACT_CFGERR;
                  window_in = base_ff;
                  count_in  = '0;
               end else if (req_ch.attempt_ok) begin
                  act_in    = ACT_OK;
                  window_in = base_ff;
                  count_in  = '0;
               end else if ((limit_ff != '0) && (count_inc >= limit_ff)) begin
                  act_in    = ACT_GIVEUP;
                  code_in   = req_ch.fail_code;
                  window_in = base_ff;
                  count_in  = '0;
               end else begin
                  act_in    = ACT_WAIT;
                  state_in  = ST_DIVIDE;
                  div_start = 1'b1;
                  if (limit_ff != '0) begin
                     count_in = count_inc;
                  end
                  // double the window unless that would pass the cap
                  if (win <= (cap >> 1)) begin
                     window_in = win << 1;
                  end else begin
                     window_in = cap;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               wait_in  = WAIT_W'(div_rem);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = act_ff;
               rsp_wait_in  = wait_ff;
               rsp_code_in  = code_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            REG_BASE_WINDOW: begin
               base_in   = csr_wdata[WINDOW_WIDTH-1:0];
               window_in = csr_wdata[WINDOW_WIDTH-1:0];
            end
            REG_MAX_WINDOW: begin
               max_in = csr_wdata[WINDOW_WIDTH-1:0];
            end
            REG_ATTEMPT_LIM: begin
               limit_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= BASE_WINDOW_RST[WINDOW_WIDTH-1:0];
         max_ff       <= MAX_WINDOW_RST[WINDOW_WIDTH-1:0];
         limit_ff     <= ATTEMPT_LIM_RST;
         window_ff    <= BASE_WINDOW_RST[WINDOW_WIDTH-1:0];
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         max_ff       <= max_in;
         limit_ff     <= limit_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      wait_ff     <= wait_in;
      code_ff     <= code_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_code_ff <= rsp_code_in;
   end

   ebj_mod_unit #(
      .RANDOM_WIDTH (RANDOM_WIDTH),
      .WINDOW_WIDTH (WINDOW_WIDTH)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_ch.random_word[RANDOM_WIDTH-1:0]),
      .divisor   (win),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.action     = rsp_act_ff;
   assign rsp_ch.wait_ms    = rsp_wait_ff;
   assign rsp_ch.final_code = rsp_code_ff;

   // the divider only finishes while the sequencer waits on it
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // a zero base window always answers with a config error
   a_cfgerr_on_zero_base: assert property (@(posedge clock) disable iff (reset)
      (accept && (base_ff == '0)) |=> ((state_ff == ST_FINISH) && (act_ff == ACT_CFGERR)))
      else $error("zero base window did not give config error");

   // only wait responses carry a wait time
   a_wait_only_on_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_act_ff != ACT_WAIT)) |-> (rsp_wait_ff == '0))
      else $error("wait time on a non-wait response");

endmodule

// ===== sim/ebj_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebj_checker: response predictor and scoreboard for the backoff controller
// Watches register writes, accepted requests and accepted responses. Keeps its
// own copy of the window, attempt count and registers, predicts one response
// per request and compares every accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module ebj_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_attempt_ok,
   input  logic [ebj_pkg::CODE_W-1:0]     req_fail_code,
   input  logic [ebj_pkg::RAND_W-1:0]     req_random_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [ebj_pkg::ACT_W-1:0]      rsp_action,
   input  logic [ebj_pkg::WAIT_W-1:0]     rsp_wait_ms,
   input  logic [ebj_pkg::CODE_W-1:0]     rsp_final_code,
   input  logic                           csr_we,
   input  logic [ebj_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ebj_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    fail_count,
   output int unsigned                    outstanding
);
   import ebj_pkg::*;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [WAIT_W-1:0] wait_ms;
      logic [CODE_W-1:0] final_code;
   } backoff_rsp_type;

   backoff_rsp_type     due_responses[$];
   logic [WAIT_W-1:0]   base_window;
   logic [WAIT_W-1:0]   max_window;
   logic [31:0]         attempt_limit;
   logic [WAIT_W-1:0]   cur_window;
   logic [31:0]         attempt_tally;

   function automatic void restart_backoff();
      cur_window    = base_window;
      attempt_tally = '0;
   endfunction

   function automatic backoff_rsp_type predict_response(
      input logic ok,
      input logic [CODE_W-1:0] code,
      input logic [RAND_W-1:0] rnd);
      backoff_rsp_type   r;
      logic [WAIT_W-1:0] win;
      logic [WAIT_W-1:0] cap;
      logic [RAND_W-1:0] rem;
      r = '0;
      if (base_window == '0) begin
         r.action = ACT_CFGERR;
         restart_backoff();
         return r;
      end
      if (ok) begin
         r.action = ACT_OK;
         restart_backoff();
         return r;
      end
      if (attempt_limit != '0) begin
         attempt_tally = attempt_tally + 32'd1;
         // compared with >= so a lowered limit still ends the sequence
         if (attempt_tally >= attempt_limit) begin
            r.action     = ACT_GIVEUP;
            r.final_code = code;
            restart_backoff();
            return r;
         end
      end
      win = (cur_window == '0) ? WAIT_W'(1) : cur_window;
      rem = rnd % RAND_W'(win);
      r.action  = ACT_WAIT;
      r.wait_ms = rem[WAIT_W-1:0];
      cap = (max_window == '0) ? WAIT_W'(1) : max_window;
      if (win <= (cap >> 1)) begin
         cur_window = win << 1;
      end else begin
         cur_window = cap;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      backoff_rsp_type want;
      backoff_rsp_type got;
      if (reset) begin
         base_window   = BASE_WINDOW_RST;
         max_window    = MAX_WINDOW_RST;
         attempt_limit = ATTEMPT_LIM_RST;
         restart_backoff();
         due_responses.delete();
         fail_count  = 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_BASE_WINDOW: begin
                  base_window = csr_wdata;
                  cur_window  = csr_wdata;
               end
               REG_MAX_WINDOW:  max_window = csr_wdata;
               REG_ATTEMPT_LIM: attempt_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            due_responses.push_back(predict_response(req_attempt_ok, req_fail_code,
                                                     req_random_word));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{action: rsp_action, wait_ms: rsp_wait_ms, final_code: rsp_final_code};
            if (due_responses.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %0d/%0d/%0d",
                        $time, got.action, got.wait_ms, got.final_code);
               fail_count = fail_count + 1;
            end else begin
               want = due_responses.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                           $time, want.action, want.wait_ms, want.final_code,
                           got.action, got.wait_ms, got.final_code);
                  fail_count = fail_count + 1;
               end
            end
         end
         outstanding <= due_responses.size();
      end
   end

endmodule

// ===== sim/tb_exponential_backoff_jitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exponential_backoff_jitter_top: testbench of the backoff controller
// Directed corner requests and register settings, then randomized retry
// sequences under several register settings, with random idle on the request
// side and random stalls on the response side. The checker scores responses.
// ----------------------------------------------------------------------------
module tb_exponential_backoff_jitter_top;
   import ebj_pkg::*;

   localparam int          PHASES       = 12;
   localparam int          PHASE_ITEMS  = 105;
   localparam int          IDLE_PCT     = 13;
   localparam int          DRAIN_CYCLES = RAND_W + 8;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  no_idle;
   int unsigned           fail_count;
   int unsigned           outstanding;
   int unsigned           cycle_count = 0;

   ebj_req_if req_ch ();
   ebj_rsp_if rsp_ch ();

   exponential_backoff_jitter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ebj_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_attempt_ok  (req_ch.attempt_ok),
      .req_fail_code   (req_ch.fail_code),
      .req_random_word (req_ch.random_word),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_action      (rsp_ch.action),
      .rsp_wait_ms     (rsp_ch.wait_ms),
      .rsp_final_code  (rsp_ch.final_code),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [RAND_W-1:0] pick_random_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return {32'd0, $urandom};
         3:       return RAND_W'($urandom_range(0, 1000));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_base_window();
      case ($urandom_range(11))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3, 4:    return $urandom;
         default: return $urandom_range(1, 2000);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_max_window();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return $urandom;
         4, 5:    return $urandom_range(1, 100000);
         default: return $urandom_range(1000, 60000);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_attempt_limit();
      case ($urandom_range(9))
         0, 1, 2: return '0;
         3:       return 32'd1;
         4:       return '1;
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   // called at a rising edge; returns at the edge that takes the request
   task automatic send_attempt(input logic ok, input logic [CODE_W-1:0] code,
                               input logic [RAND_W-1:0] rnd);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 70);
      end
      while (gap > 0) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         gap--;
      end
      req_ch.valid       <= 1'b1;
      req_ch.attempt_ok  <= ok;
      req_ch.fail_code   <= code;
      req_ch.random_word <= rnd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // no request in flight and every response back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] base_ms,
                            input logic [CSR_DATA_W-1:0] max_ms,
                            input logic [CSR_DATA_W-1:0] limit);
      wait_idle();
      write_reg(REG_BASE_WINDOW, base_ms);
      write_reg(REG_MAX_WINDOW, max_ms);
      write_reg(REG_ATTEMPT_LIM, limit);
   endtask

   initial begin
      int sent;
      int fails;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      no_idle            <= 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.attempt_ok  <= 1'b0;
      req_ch.fail_code   <= '0;
      req_ch.random_word <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at their reset values
      send_attempt(1'b1, 8'hFF, '1);
      send_attempt(1'b0, 8'h00, '1);
      send_attempt(1'b0, 8'hFF, '0);
      send_attempt(1'b0, 8'h5A, {$urandom, $urandom});
      send_attempt(1'b1, 8'h00, '0);

      // limit of one gives up on the first failure
      configure(32'd1, '1, 32'd1);
      send_attempt(1'b0, 8'hA5, '1);

      // base above max, then give up on the third failure
      configure(32'd1000, 32'd300, 32'd3);
      send_attempt(1'b0, 8'h11, {$urandom, $urandom});
      send_attempt(1'b0, 8'h22, {$urandom, $urandom});
      send_attempt(1'b0, 8'h3C, {$urandom, $urandom});

      // zero max window caps at one
      configure(32'd5, 32'd0, 32'd10);
      send_attempt(1'b0, 8'h01, '1);
      send_attempt(1'b0, 8'h02, {$urandom, $urandom});
      send_attempt(1'b0, 8'h03, {$urandom, $urandom});

      // limit lowered below the count already reached
      wait_idle();
      write_reg(REG_ATTEMPT_LIM, 32'd2);
      send_attempt(1'b0, 8'hC3, {$urandom, $urandom});

      // all registers at their top values
      configure('1, '1, '1);
      send_attempt(1'b0, 8'h7E, '1);
      send_attempt(1'b0, 8'h81, {$urandom, $urandom});
      send_attempt(1'b1, 8'h99, {$urandom, $urandom});

      // base write in the middle of a sequence reloads the window
      configure(32'd1, '1, 32'd0);
      send_attempt(1'b0, 8'h44, '1);
      send_attempt(1'b0, 8'h55, '1);
      wait_idle();
      write_reg(REG_BASE_WINDOW, 32'd7);
      send_attempt(1'b0, 8'h66, '1);

      // zero base window answers config error either way
      configure(32'd0, 32'd30000, 32'd0);
      send_attempt(1'b0, 8'hFF, '1);
      send_attempt(1'b1, 8'h00, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         configure(pick_base_window(), pick_max_window(), pick_attempt_limit());
         no_idle <= (phase == 5 || phase == 6);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9) < 8) begin
               // retry sequence: failures, then usually a success
               fails = ($urandom_range(3) == 0) ? $urandom_range(9, 40)
                                                : $urandom_range(0, 8);
               for (int k = 0; k < fails; k++) begin
                  send_attempt(1'b0, CODE_W'($urandom_range(255)), pick_random_word());
                  sent++;
               end
               if ($urandom_range(3) != 0) begin
                  send_attempt(1'b1, CODE_W'($urandom_range(255)), pick_random_word());
                  sent++;
               end
            end else begin
               send_attempt(1'($urandom_range(1)), CODE_W'($urandom_range(255)),
                            pick_random_word());
               sent++;
            end
         end
      end

      wait_idle();
      no_idle <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
